@@ hw/rtl/expiry_timer_queue_unit_macros.svh @@
// Assertion macros for the expiry timer queue unit.
// Used by the top level; expects clk and arst_n in scope.
`ifndef EXPIRY_TIMER_QUEUE_UNIT_MACROS_SVH
`define EXPIRY_TIMER_QUEUE_UNIT_MACROS_SVH

// same-cycle implication
`define ETQ_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("etq assertion failed");

// next-cycle implication
`define ETQ_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("etq assertion failed");

`endif

@@ hw/rtl/etq_pkg.sv @@
// Shared types, codes and sizes for the expiry timer queue unit.
// No dependencies.
package etq_pkg;

	localparam int TIMER_SLOTS = 16;
	localparam int MAX_OUT     = 16;
	localparam int SLOT_W      = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
	localparam int NUM_W       = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
	localparam int ID_W        = 5;
	localparam int EXT_W       = ((SLOT_W > ID_W) ? SLOT_W : ID_W) + 1;

	localparam logic [1:0] MODE_POST   = 2'd0;
	localparam logic [1:0] MODE_CANCEL = 2'd1;
	localparam logic [1:0] MODE_TICK   = 2'd2;

	localparam logic [2:0] STS_POSTED    = 3'd0;
	localparam logic [2:0] STS_FULL      = 3'd1;
	localparam logic [2:0] STS_CANCELLED = 3'd2;
	localparam logic [2:0] STS_NOT_FOUND = 3'd3;
	localparam logic [2:0] STS_EXPIRED   = 3'd4;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] delay_ms;
		logic [4:0]  cancel_id;
	} in_word_t;

	typedef struct packed {
		logic [2:0]      status;
		logic [ID_W-1:0] timer_id;
		logic            last;
	} out_word_t;

	typedef struct packed {
		logic accept;
		logic scan_start;
		logic load_exp;
		logic cap;
		logic retire;
	} etq_cmd_t;

	typedef struct packed {
		logic scan_busy;
		logic found;
		logic res_last;
	} etq_sts_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RESP,
		S_SCAN,
		S_EMIT
	} etq_state_t;

endpackage

@@ hw/rtl/etq_datapath.sv @@
// Timer table, time and insert counters, slot scan and result register.
// Depends on etq_pkg.
module etq_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  etq_pkg::etq_cmd_t cmd,
	input  etq_pkg::in_word_t in_word,
	output etq_pkg::etq_sts_t sts,
	output etq_pkg::out_word_t out_word
);
	import etq_pkg::*;

	logic [63:0]       time_q;
	logic [31:0]       insert_q;
	logic              valid_q [TIMER_SLOTS];
	logic [63:0]       dl_q    [TIMER_SLOTS];
	logic [31:0]       stamp_q [TIMER_SLOTS];

	logic              scan_act_q;
	logic [SLOT_W-1:0] idx_q;

	logic              v_s1;
	logic              hit_s1;
	logic [63:0]       dl_s1;
	logic [31:0]       age_s1;
	logic [SLOT_W-1:0] idx_s1;

	logic              found_q;
	logic [63:0]       best_dl_q;
	logic [31:0]       best_age_q;
	logic [SLOT_W-1:0] best_idx_q;
	logic [CNT_W-1:0]  due_cnt_q;

	out_word_t         res_q;

	logic              free_found;
	logic [SLOT_W-1:0] free_idx;
	logic [EXT_W-1:0]  cid_ext;
	logic [SLOT_W-1:0] cidx;
	logic              cancel_hit;
	logic              take;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx   = SLOT_W'(i);
			end
		end
	end

	assign cid_ext    = EXT_W'(in_word.cancel_id);
	assign cidx       = SLOT_W'(cid_ext - EXT_W'(1));
	assign cancel_hit = (cid_ext != '0) && (cid_ext <= EXT_W'(TIMER_SLOTS)) && valid_q[cidx];

	assign take = !found_q || (dl_s1 < best_dl_q) ||
		((dl_s1 == best_dl_q) && (age_s1 > best_age_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q   <= '0;
			insert_q <= '0;
			for (int i = 0; i < TIMER_SLOTS; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else begin
			if (cmd.accept) begin
				case (in_word.mode)
					MODE_POST: begin
						if (free_found) begin
							valid_q[free_idx] <= 1'b1;
							insert_q          <= insert_q + 32'd1;
						end
					end
					MODE_CANCEL: begin
						if (cancel_hit) begin
							valid_q[cidx] <= 1'b0;
						end
					end
					MODE_TICK: begin
						time_q <= time_q + 64'd1;
					end
					default: begin
					end
				endcase
			end
			if (cmd.retire) begin
				valid_q[best_idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && (in_word.mode == MODE_POST) && free_found) begin
			dl_q[free_idx]    <= time_q + 64'(in_word.delay_ms);
			stamp_q[free_idx] <= insert_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_act_q <= 1'b0;
			idx_q      <= '0;
			v_s1       <= 1'b0;
			found_q    <= 1'b0;
			due_cnt_q  <= '0;
		end else begin
			v_s1 <= scan_act_q;
			if (cmd.scan_start) begin
				scan_act_q <= 1'b1;
				idx_q      <= '0;
				found_q    <= 1'b0;
				due_cnt_q  <= '0;
			end else begin
				if (scan_act_q) begin
					idx_q <= idx_q + SLOT_W'(1);
					if (idx_q == SLOT_W'(TIMER_SLOTS - 1)) begin
						scan_act_q <= 1'b0;
					end
				end
				if (v_s1 && hit_s1) begin
					due_cnt_q <= due_cnt_q + CNT_W'(1);
					if (take) begin
						found_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_act_q) begin
			hit_s1 <= valid_q[idx_q] && (dl_q[idx_q] <= time_q);
			dl_s1  <= dl_q[idx_q];
			age_s1 <= insert_q - stamp_q[idx_q];
			idx_s1 <= idx_q;
		end
		if (v_s1 && hit_s1 && take) begin
			best_dl_q  <= dl_s1;
			best_age_q <= age_s1;
			best_idx_q <= idx_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			case (in_word.mode)
				MODE_POST: begin
					if (free_found) begin
						res_q <= '{STS_POSTED, ID_W'(EXT_W'(free_idx) + EXT_W'(1)), 1'b1};
					end else begin
						res_q <= '{STS_FULL, '0, 1'b1};
					end
				end
				MODE_CANCEL: begin
					if (cancel_hit) begin
						res_q <= '{STS_CANCELLED, in_word.cancel_id, 1'b1};
					end else begin
						res_q <= '{STS_NOT_FOUND, '0, 1'b1};
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.load_exp) begin
			res_q <= '{STS_EXPIRED, ID_W'(EXT_W'(best_idx_q) + EXT_W'(1)),
				(due_cnt_q == CNT_W'(1)) || cmd.cap};
		end
	end

	assign sts.scan_busy = scan_act_q || v_s1;
	assign sts.found     = found_q;
	assign sts.res_last  = res_q.last;
	assign out_word      = res_q;

endmodule

@@ hw/rtl/etq_ctrl.sv @@
// Sequencer for post, cancel and tick words of the expiry timer queue.
// Depends on etq_pkg.
module etq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [1:0]        mode,
	input  logic              out_ready,
	input  etq_pkg::etq_sts_t sts,
	output logic              in_ready,
	output logic              out_valid,
	output etq_pkg::etq_cmd_t cmd
);
	import etq_pkg::*;

	etq_state_t       state_q;
	etq_state_t       state_d;
	logic [NUM_W-1:0] n_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (mode)
						MODE_POST:   state_d = S_RESP;
						MODE_CANCEL: state_d = S_RESP;
						MODE_TICK:   state_d = S_SCAN;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_RESP: begin
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if (!sts.scan_busy) begin
					state_d = sts.found ? S_EMIT : S_IDLE;
				end
			end
			S_EMIT: begin
				if (out_ready) begin
					state_d = sts.res_last ? S_IDLE : S_SCAN;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = (state_q == S_IDLE);
		out_valid      = (state_q == S_RESP) || (state_q == S_EMIT);
		cmd.accept     = (state_q == S_IDLE) && in_valid;
		cmd.scan_start = ((state_q == S_IDLE) && in_valid && (mode == MODE_TICK)) ||
			((state_q == S_EMIT) && out_ready && !sts.res_last);
		cmd.load_exp   = (state_q == S_SCAN) && !sts.scan_busy && sts.found;
		cmd.cap        = (n_q == NUM_W'(MAX_OUT - 1));
		cmd.retire     = (state_q == S_EMIT) && out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.accept) begin
				n_q <= '0;
			end else if ((state_q == S_EMIT) && out_ready && !sts.res_last) begin
				n_q <= n_q + NUM_W'(1);
			end
		end
	end

endmodule

@@ hw/rtl/expiry_timer_queue_unit.sv @@
// Top level of the expiry timer queue: controller plus datapath.
// Depends on etq_pkg, etq_ctrl, etq_datapath and the macros header.
//
//  channel | handshake           | word
//  --------+---------------------+-------------------------------
//  in      | in_valid / in_ready | mode, delay_ms, cancel_id
//  out     | out_valid/out_ready | status, timer_id, last
//
// Post and cancel: result shown the next cycle after acceptance.
// Tick: each result costs one full scan of all TIMER_SLOTS slots plus the
// output handshake; a tick with nothing due ends after one scan with no result.
// One word in flight; in_ready is low until its last result is taken.
// Reset clears time, insert count and all slot valid bits at once.
`include "expiry_timer_queue_unit_macros.svh"

module expiry_timer_queue_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  etq_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_ready,
	output etq_pkg::out_word_t out_word
);
	import etq_pkg::*;

	etq_cmd_t cmd;
	etq_sts_t sts;

	etq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.mode      (in_word.mode),
		.out_ready (out_ready),
		.sts       (sts),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	etq_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_word  (in_word),
		.sts      (sts),
		.out_word (out_word)
	);

	`ETQ_ASSERT_IMP(a_no_overlap, out_valid, !in_ready)
	`ETQ_ASSERT_NXT(a_last_frees, out_valid && out_ready && out_word.last, in_ready)
	`ETQ_ASSERT_NXT(a_more_holds, out_valid && out_ready && !out_word.last, !in_ready)

endmodule
